// File: rtl/catmull_rom_spline_sampler_macros.svh
// assertion macros for the checker file of the spline sampler
// no dependencies; pulled in by `include
`ifndef CATMULL_ROM_SPLINE_SAMPLER_MACROS_SVH
`define CATMULL_ROM_SPLINE_SAMPLER_MACROS_SVH

// same-cycle implication
`define CRSS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spline sampler check failed");

// next-cycle implication
`define CRSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spline sampler check failed");

`endif

// File: rtl/crss_pkg.sv
// shared types and constants of the catmull-rom spline sampler
// no dependencies; used by the top level and its checker
package crss_pkg;

  localparam int COORD_W = 32;
  localparam int TPOS_W  = 17;
  localparam int FRAC_W  = 16;
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 6;
  localparam int AXES    = 3;

  // blend term widths
  localparam int A1_W   = 33;
  localparam int A_W    = 36;
  localparam int M1_W   = A1_W + TPOS_W + 1;
  localparam int PROD_W = 54;
  localparam int RES_W  = PROD_W - FRAC_W - 1;

  localparam logic [TPOS_W-1:0] ONE_Q16 = 17'h10000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [AXES-1:0][COORD_W-1:0] point_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

endpackage

// File: rtl/crss_ram.sv
// generic ram: one write port, two registered read ports
// no dependencies
module crss_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/catmull_rom_spline_sampler.sv
// uniform catmull-rom spline sampler over a table of 3-d q16.16 points
// depends on crss_pkg and crss_ram
//
//   channel   signals                                         direction
//   input     in_valid, in_stall, op, point_index,            in
//             point_x/y/z, sample_position
//   output    out_valid, out_stall, curve_x/y/z               out
//   config    cfg_we, cfg_wdata (point_count)                 in
//
// one item per cycle while no output stall holds the pipe; a query passes six
// register stages to the output register: clamp and scale, segment pick
// and table read, basis terms, products, last product and partial sum, round and
// saturate.
// the point table sits in two copies of a two-read-port ram so the four
// neighbors are read together; loads write it in the same stage.
// reset clears valid bits and point_count only; table contents are not reset.
// an output stall first fills bubbles, then backs up to in_stall.
module catmull_rom_spline_sampler
  import crss_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       op,
  input  logic [INDEX_W-1:0]         point_index,
  input  logic signed [COORD_W-1:0]  point_x,
  input  logic signed [COORD_W-1:0]  point_y,
  input  logic signed [COORD_W-1:0]  point_z,
  input  logic [TPOS_W-1:0]          sample_position,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [COORD_W-1:0]  curve_x,
  output logic signed [COORD_W-1:0]  curve_y,
  output logic signed [COORD_W-1:0]  curve_z,
  input  logic                       cfg_we,
  input  logic [COUNT_W-1:0]         cfg_wdata
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int SW = TPOS_W + AW;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = 54'sd65536;
  localparam logic signed [RES_W-1:0]  SAT_HI     = 37'sd2147483647;
  localparam logic signed [RES_W-1:0]  SAT_LO     = -37'sd2147483648;

  logic [COUNT_W-1:0] point_count;

  // pipeline control
  logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !out_valid || !out_stall;
  assign rdy5 = !valid_s5 || rdy6;
  assign rdy4 = !valid_s4 || rdy5;
  assign rdy3 = !valid_s3 || rdy4;
  assign rdy2 = !valid_s2 || rdy3;
  assign rdy1 = !valid_s1 || rdy2;
  assign in_stall = !rdy1;

  // stage 0: clamp t, cap the count, scale
  logic [TPOS_W-1:0] t_clamp;
  logic [NW-1:0]     n_in;
  logic              small_in;
  logic [AW-1:0]     nm1_in;
  logic [SW-1:0]     scaled_in;

  always_comb begin
    t_clamp   = (sample_position > ONE_Q16) ? ONE_Q16 : sample_position;
    n_in      = (32'(point_count) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(point_count);
    small_in  = (n_in <= NW'(1));
    nm1_in    = AW'(n_in - NW'(1));
    scaled_in = small_in ? '0 : SW'(t_clamp) * SW'(nm1_in);
  end

  // stage 1 registers
  logic               load1;
  logic [INDEX_W-1:0] idx1;
  point_t             pt1;
  logic [SW-1:0]      scaled1;
  logic [NW-1:0]      n1;
  logic               small1;
  logic               zero1;

  // segment pick and neighbor indices
  logic [AW-1:0]     seg_raw, nm2, seg, i0, i2, i3;
  logic [NW-1:0]     seg_p2;
  logic [TPOS_W-1:0] u_s1;
  logic              idx_ok1;

  always_comb begin
    seg_raw = AW'(scaled1 >> FRAC_W);
    nm2     = AW'(n1 - NW'(2));
    seg     = small1 ? '0 : ((seg_raw > nm2) ? nm2 : seg_raw);
    u_s1    = TPOS_W'(scaled1 - (SW'(seg) << FRAC_W));
    i0      = (seg == '0) ? '0 : seg - AW'(1);
    i2      = small1 ? '0 : seg + AW'(1);
    seg_p2  = NW'(seg) + NW'(2);
    if (small1) begin
      i3 = '0;
    end else if (seg_p2 < n1) begin
      i3 = AW'(seg_p2);
    end else begin
      i3 = AW'(n1 - NW'(1));
    end
    idx_ok1 = (32'(idx1) < 32'(MAX_POINTS));
  end

  // table: low copy gives p0 and p1, high copy p2 and p3
  logic          tab_we;
  logic [AW-1:0] tab_waddr;
  point_t        rd_p0, rd_p1, rd_p2, rd_p3;

  assign tab_we    = valid_s1 && load1 && idx_ok1 && rdy2;
  assign tab_waddr = AW'(idx1);

  crss_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MAX_POINTS)
  ) u_ram_lo (
    .clk     (clk),
    .we      (tab_we),
    .waddr   (tab_waddr),
    .wdata   (pt1),
    .re      (rdy2),
    .raddr_a (i0),
    .raddr_b (seg),
    .rdata_a (rd_p0),
    .rdata_b (rd_p1)
  );

  crss_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MAX_POINTS)
  ) u_ram_hi (
    .clk     (clk),
    .we      (tab_we),
    .waddr   (tab_waddr),
    .wdata   (pt1),
    .re      (rdy2),
    .raddr_a (i2),
    .raddr_b (i3),
    .rdata_a (rd_p2),
    .rdata_b (rd_p3)
  );

  // stage 2 .. 5 registers
  logic              zero2, zero3, zero4, zero5;
  logic [TPOS_W-1:0] u2, u3, t2_3, t3_4;
  logic [TPOS_W-1:0] t2_next, t3_next;

  logic signed [TPOS_W:0] u3_sgn, t2_sgn, t3_sgn;

  coord_t                   p1_3 [AXES];
  logic signed [A1_W-1:0]   a1_3 [AXES];
  logic signed [A_W-1:0]    a2_3 [AXES];
  logic signed [A_W-1:0]    a3_3 [AXES];
  coord_t                   p1_4 [AXES];
  logic signed [A_W-1:0]    a3_4 [AXES];
  logic signed [M1_W-1:0]   m1_4 [AXES];
  logic signed [PROD_W-1:0] m2_4 [AXES];
  logic signed [PROD_W-1:0] acc5 [AXES];
  logic signed [PROD_W-1:0] m3_5 [AXES];
  logic signed [COORD_W-1:0] res5 [AXES];

  always_comb begin
    t2_next = TPOS_W'((34'(u2) * 34'(u2) + 34'd32768) >> FRAC_W);
    t3_next = TPOS_W'((34'(t2_3) * 34'(u3) + 34'd32768) >> FRAC_W);
    u3_sgn  = $signed({1'b0, u3});
    t2_sgn  = $signed({1'b0, t2_3});
    t3_sgn  = $signed({1'b0, t3_4});
  end

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    coord_t p0, p1, p2, p3;
    logic signed [A1_W-1:0]   a1_next;
    logic signed [A_W-1:0]    a2_next, a3_next;
    logic signed [M1_W-1:0]   m1_next;
    logic signed [PROD_W-1:0] m2_next, m3_next, acc_next, sum;
    logic signed [PROD_W-1:0] sh;
    logic signed [RES_W-1:0]  r;

    always_comb begin
      p0 = $signed(rd_p0[a]);
      p1 = $signed(rd_p1[a]);
      p2 = $signed(rd_p2[a]);
      p3 = $signed(rd_p3[a]);
      a1_next = A1_W'(p2) - A1_W'(p0);
      a2_next = 36'sd2 * A_W'(p0) - 36'sd5 * A_W'(p1) + 36'sd4 * A_W'(p2) - A_W'(p3);
      a3_next = 36'sd3 * A_W'(p1) - 36'sd3 * A_W'(p2) + A_W'(p3) - A_W'(p0);
      m1_next = a1_3[a] * u3_sgn;
      m2_next = a2_3[a] * t2_sgn;
      m3_next = a3_4[a] * t3_sgn;
      acc_next = (PROD_W'(p1_4[a]) <<< (FRAC_W + 1)) + PROD_W'(m1_4[a]) + m2_4[a];
      // floor of (sum + 2^16) / 2^17, then clip to 32 bits
      sum = acc5[a] + m3_5[a] + ROUND_HALF;
      sh  = sum >>> (FRAC_W + 1);
      r   = sh[RES_W-1:0];
      if (r > SAT_HI) begin
        res5[a] = SAT_HI[COORD_W-1:0];
      end else if (r < SAT_LO) begin
        res5[a] = SAT_LO[COORD_W-1:0];
      end else begin
        res5[a] = r[COORD_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy3) begin
        p1_3[a] <= p1;
        a1_3[a] <= a1_next;
        a2_3[a] <= a2_next;
        a3_3[a] <= a3_next;
      end
      if (rdy4) begin
        p1_4[a] <= p1_3[a];
        a3_4[a] <= a3_3[a];
        m1_4[a] <= m1_next;
        m2_4[a] <= m2_next;
      end
      if (rdy5) begin
        acc5[a] <= acc_next;
        m3_5[a] <= m3_next;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      valid_s1    <= 1'b0;
      valid_s2    <= 1'b0;
      valid_s3    <= 1'b0;
      valid_s4    <= 1'b0;
      valid_s5    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        point_count <= cfg_wdata;
      end
      if (rdy1) begin
        valid_s1 <= in_valid;
      end
      // loads leave the pipe at stage 1, where in-range ones write the table
      if (rdy2) begin
        valid_s2 <= valid_s1 && !load1;
      end
      if (rdy3) begin
        valid_s3 <= valid_s2;
      end
      if (rdy4) begin
        valid_s4 <= valid_s3;
      end
      if (rdy5) begin
        valid_s5 <= valid_s4;
      end
      if (rdy6) begin
        out_valid <= valid_s5;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy1) begin
      load1   <= (op == OP_LOAD);
      idx1    <= point_index;
      pt1     <= {point_z, point_y, point_x};
      scaled1 <= scaled_in;
      n1      <= n_in;
      small1  <= small_in;
      zero1   <= (n_in == '0);
    end
    if (rdy2) begin
      zero2 <= zero1;
      u2    <= u_s1;
    end
    if (rdy3) begin
      zero3 <= zero2;
      u3    <= u2;
      t2_3  <= t2_next;
    end
    if (rdy4) begin
      zero4 <= zero3;
      t3_4  <= t3_next;
    end
    if (rdy5) begin
      zero5 <= zero4;
    end
    if (rdy6) begin
      curve_x <= zero5 ? '0 : res5[0];
      curve_y <= zero5 ? '0 : res5[1];
      curve_z <= zero5 ? '0 : res5[2];
    end
  end

endmodule

// File: rtl/crss_checker.sv
// port-level checks of the spline sampler, bound to the top level
// depends on crss_pkg and catmull_rom_spline_sampler_macros.svh
`include "catmull_rom_spline_sampler_macros.svh"

module crss_checker
  import crss_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      op,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [COORD_W-1:0] curve_x,
  input logic signed [COORD_W-1:0] curve_y,
  input logic signed [COORD_W-1:0] curve_z
);

  // recent history of out_stall, newest in bit 0
  logic [4:0] stall_hist;

  always_ff @(posedge clk) begin
    stall_hist <= {stall_hist[3:0], out_stall};
  end

  // no result survives a reset cycle
  `CRSS_ASSERT_NEXT(a_reset_empties, clk, 1'b0, rst, !out_valid)

  // a free output register means the whole pipe can move
  `CRSS_ASSERT_NOW(a_free_output, clk, rst, !out_valid || !out_stall, !in_stall)

  // with no recent output stall an accepted query shows up on out_valid
  `CRSS_ASSERT_NOW(a_query_latency, clk, rst, in_valid && !in_stall && op == OP_SAMPLE, ##6 (out_valid || |stall_hist))

  // stalled item holds
  `CRSS_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && out_stall, out_valid && $stable(curve_x) && $stable(curve_y) && $stable(curve_z))

endmodule

bind catmull_rom_spline_sampler crss_checker u_crss_checker (.*);
